>>> hdl/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants of the lightmap exposure tone-mapping unit.
// ----------------------------------------------------------------------------
package lmt_pkg;

   localparam int NUM_STAGES = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_AMBIENT_RED = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMBIENT_GREEN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMBIENT_BLUE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPOSURE_RATE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPOSURE_CEILING = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPOSURE_ENABLE = 3'd5;

   localparam logic [23:0] AMBIENT_RESET = 24'd0;
   localparam logic [15:0] RATE_RESET = 16'd7373;
   localparam logic [15:0] CEILING_RESET = 16'd2048;

   typedef struct packed {
      logic [23:0] red_in;
      logic [23:0] green_in;
      logic [23:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // settings shared by all three channels
   typedef struct packed {
      logic [15:0] exposure_rate;
      logic [15:0] exposure_ceiling;
      logic        exposure_enable;
   } expo_cfg_type;

endpackage

>>> hdl/lmt_channel.sv
// ----------------------------------------------------------------------------
// lmt_channel
// Eight-stage datapath for one color channel: ambient add, exposure curve
// through 2^-x table interpolation (bypassed when exposure is off), clamp and scale to 8 bits.
// ----------------------------------------------------------------------------
module lmt_channel
   import lmt_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic [NUM_STAGES-1:0] stage_load,
   input  logic [23:0]           chan_in,
   input  logic [23:0]           ambient,
   input  expo_cfg_type          cfg,
   output logic [7:0]            chan_out
);

   localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
   localparam int PW = 16 + IDX_W;
   localparam logic [PW-1:0] ENTRIES_P = PW'(EXP_TABLE_ENTRIES);

   // shift-subtract quotient, used only while the table is built
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      logic [64:0]     rem;
      begin
         quo = 64'd0;
         rem = 65'd0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
               rem = rem - {1'b0, den};
               quo[b] = 1'b1;
            end
         end
         udiv = quo;
      end
   endfunction

   // round(2^(-i/E)) in Q1.16, elaboration only
   function automatic logic [16:0] exp_entry(input int idx);
      longint unsigned y;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q;
      begin
         y = udiv(longint'(idx) * 64'd2977044472, 64'(EXP_TABLE_ENTRIES));
         term = 64'd1 << 32;
         sum = 64'd1 << 32;
         for (int k = 1; k <= 24; k++) begin
            term = udiv((term * y) >> 32, 64'(k));
            sum = sum + term;
         end
         q = udiv((64'd1 << 48) + (sum >> 1), sum);
         if (idx == 0) begin
            exp_entry = ONE_Q16;
         end else begin
            exp_entry = q[16:0];
         end
      end
   endfunction

   // each row holds T[i] and the step down to T[i+1]
   logic [16:0] rom_a [EXP_TABLE_ENTRIES];
   logic [16:0] rom_d [EXP_TABLE_ENTRIES];

   for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++) begin : g_rom
      localparam logic [16:0] TA = exp_entry(gi);
      localparam logic [16:0] TB = exp_entry(gi + 1);
      assign rom_a[gi] = TA;
      assign rom_d[gi] = (TA >= TB) ? 17'(TA - TB) : 17'd0;
   end

   // stage registers
   logic [23:0] c_ff;
   logic [27:0] t_ff;
   logic [16:0] byp1_ff, byp2_ff, byp3_ff, byp4_ff, byp5_ff;
   logic [15:0] f_ff;
   logic        big2_ff, big3_ff, big4_ff;
   logic [4:0]  sh2_ff, sh3_ff, sh4_ff;
   logic [16:0] a_ff, d_ff;
   logic [15:0] r_ff;
   logic [16:0] m_ff;
   logic [16:0] ome_ff;
   logic [16:0] y_ff;
   logic [7:0]  out_ff;

   logic [24:0]    sum_in;
   logic [23:0]    c_in;
   logic [39:0]    prod_t;
   logic [44:0]    prod_u;
   logic [12:0]    n_int;
   logic [PW-1:0]  p_frac;
   logic [IDX_W-1:0] idx;
   logic [32:0]    prod_m;
   logic [16:0]    e_val;
   logic [32:0]    prod_y;
   logic [20:0]    y_exp;
   logic [16:0]    y_in;
   logic [24:0]    scaled;

   always_comb begin
      sum_in = {1'b0, chan_in} + {1'b0, ambient};
      c_in = sum_in[24] ? 24'hFF_FFFF : sum_in[23:0];
      prod_t = 40'(c_ff) * 40'(cfg.exposure_rate);
      prod_u = 45'(t_ff) * 45'(LOG2E_Q16);
      n_int = prod_u[44:32];
      p_frac = PW'(f_ff) * ENTRIES_P;
      idx = p_frac[PW-1:16];
      prod_m = 33'(d_ff) * 33'(r_ff);
      e_val = big4_ff ? 17'd0 : (m_ff >> sh4_ff);
      prod_y = 33'(cfg.exposure_ceiling) * 33'(ome_ff);
      y_exp = prod_y[32:12];
      if (!cfg.exposure_enable) begin
         y_in = byp5_ff;
      end else if (y_exp > 21'(ONE_Q16)) begin
         y_in = ONE_Q16;
      end else begin
         y_in = y_exp[16:0];
      end
      scaled = {y_ff, 8'd0} - 25'(y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         c_ff <= c_in;
      end
      if (stage_load[1]) begin
         t_ff <= prod_t[39:12];
         byp1_ff <= (c_ff > 24'(ONE_Q16)) ? ONE_Q16 : c_ff[16:0];
      end
      if (stage_load[2]) begin
         f_ff <= prod_u[31:16];
         big2_ff <= (n_int >= 13'd17);
         sh2_ff <= n_int[4:0];
         byp2_ff <= byp1_ff;
      end
      if (stage_load[3]) begin
         a_ff <= rom_a[idx];
         d_ff <= rom_d[idx];
         r_ff <= p_frac[15:0];
         big3_ff <= big2_ff;
         sh3_ff <= sh2_ff;
         byp3_ff <= byp2_ff;
      end
      if (stage_load[4]) begin
         m_ff <= a_ff - prod_m[32:16];
         big4_ff <= big3_ff;
         sh4_ff <= sh3_ff;
         byp4_ff <= byp3_ff;
      end
      if (stage_load[5]) begin
         ome_ff <= ONE_Q16 - e_val;
         byp5_ff <= byp4_ff;
      end
      if (stage_load[6]) begin
         y_ff <= y_in;
      end
      if (stage_load[7]) begin
         out_ff <= scaled[23:16];
      end
   end

   assign chan_out = out_ff;

endmodule

>>> hdl/lightmap_exposure_tonemap_unit.sv
// 8 register stages lie between input transfer and result valid.
// Throughput: one texel per cycle; each stage holds when the one after it
// is full and stalled, empty stages fill while the output waits.
// Reset clears all stage valid bits and loads the register defaults
// (ambient 0, rate 1.8, ceiling 0.5, exposure on).
// ----------------------------------------------------------------------------
// lightmap_exposure_tonemap_unit
// Exposure tone mapping of HDR RGB lightmap texels to 8-bit RGB.
// ----------------------------------------------------------------------------
module lightmap_exposure_tonemap_unit
   import lmt_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [23:0]  amb_red_ff, amb_green_ff, amb_blue_ff;
   expo_cfg_type cfg_ff;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stage_rdy;
   logic [NUM_STAGES-1:0] stage_load;
   logic [NUM_STAGES-1:0] up_vld;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_red_ff <= AMBIENT_RESET;
         amb_green_ff <= AMBIENT_RESET;
         amb_blue_ff <= AMBIENT_RESET;
         cfg_ff.exposure_rate <= RATE_RESET;
         cfg_ff.exposure_ceiling <= CEILING_RESET;
         cfg_ff.exposure_enable <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_AMBIENT_RED:      amb_red_ff <= csr_data[23:0];
            CSR_AMBIENT_GREEN:    amb_green_ff <= csr_data[23:0];
            CSR_AMBIENT_BLUE:     amb_blue_ff <= csr_data[23:0];
            CSR_EXPOSURE_RATE:    cfg_ff.exposure_rate <= csr_data[15:0];
            CSR_EXPOSURE_CEILING: cfg_ff.exposure_ceiling <= csr_data[15:0];
            CSR_EXPOSURE_ENABLE:  cfg_ff.exposure_enable <= csr_data[0];
            default: ;
         endcase
      end
   end

   // a stage can take a transfer when empty or when its content moves on
   always_comb begin
      up_vld = {vld_ff[NUM_STAGES-2:0], req_valid};
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         if (i == NUM_STAGES - 1) begin
            stage_rdy[i] = !vld_ff[i] || rsp_ready;
         end else begin
            stage_rdy[i] = !vld_ff[i] || stage_rdy[i+1];
         end
      end
      stage_load = stage_rdy & up_vld;
      vld_in = (stage_rdy & up_vld) | (~stage_rdy & vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stage_rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   lmt_channel #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_red (
      .clock      (clock),
      .stage_load (stage_load),
      .chan_in    (req_data.red_in),
      .ambient    (amb_red_ff),
      .cfg        (cfg_ff),
      .chan_out   (rsp_data.red_out)
   );

   lmt_channel #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_green (
      .clock      (clock),
      .stage_load (stage_load),
      .chan_in    (req_data.green_in),
      .ambient    (amb_green_ff),
      .cfg        (cfg_ff),
      .chan_out   (rsp_data.green_out)
   );

   lmt_channel #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_blue (
      .clock      (clock),
      .stage_load (stage_load),
      .chan_in    (req_data.blue_in),
      .ambient    (amb_blue_ff),
      .cfg        (cfg_ff),
      .chan_out   (rsp_data.blue_out)
   );

endmodule
